/* sv/mscc_pkg.sv */
// shared types, constants and helpers for the marching-squares cell contour block
// no dependencies; imported by every module of the block
`default_nettype none

package mscc_pkg;

   localparam int VAL_W  = 32;
   localparam int IDX_W  = 18;
   localparam int PROD_W = 51;
   localparam int QUO_W  = 31;
   localparam int LANES  = 4;

   localparam int COORD_BITS_DEF = 16;
   localparam int SIDE_MAX_DEF   = 128;

   localparam int CSR_IDX_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X_ORIGIN = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_X_PITCH  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_ORIGIN = 8'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_PITCH  = 8'd4;

   localparam logic signed [VAL_W-1:0] PITCH_RST = 32'sd65536;

   // saddle with bottom-left and top-right above
   localparam logic [3:0] CODE_SADDLE_BL_TR = 4'd5;

   // crossing points, one lane each, in this order
   typedef enum logic [1:0] {PT_B, PT_R, PT_T, PT_L} pt_type;

   typedef struct packed {
      logic [1:0] cnt;
      pt_type     a0;
      pt_type     b0;
      pt_type     a1;
      pt_type     b1;
   } sel_type;

   // saddles hold the left-top / bottom-right pairing; the other pairing is picked at the output
   localparam sel_type SEG_TABLE [16] = '{
      '{2'd0, PT_L, PT_L, PT_L, PT_L},
      '{2'd1, PT_L, PT_B, PT_L, PT_L},
      '{2'd1, PT_B, PT_R, PT_L, PT_L},
      '{2'd1, PT_L, PT_R, PT_L, PT_L},
      '{2'd1, PT_T, PT_R, PT_L, PT_L},
      '{2'd2, PT_L, PT_T, PT_B, PT_R},
      '{2'd1, PT_B, PT_T, PT_L, PT_L},
      '{2'd1, PT_L, PT_T, PT_L, PT_L},
      '{2'd1, PT_L, PT_T, PT_L, PT_L},
      '{2'd1, PT_B, PT_T, PT_L, PT_L},
      '{2'd2, PT_L, PT_T, PT_B, PT_R},
      '{2'd1, PT_T, PT_R, PT_L, PT_L},
      '{2'd1, PT_L, PT_R, PT_L, PT_L},
      '{2'd1, PT_B, PT_R, PT_L, PT_L},
      '{2'd1, PT_L, PT_B, PT_L, PT_L},
      '{2'd0, PT_L, PT_L, PT_L, PT_L}
   };

   typedef struct packed {
      logic               den_zero;
      logic               opp;
      logic               f_one;
      logic [VAL_W-1:0]   d;
      logic [VAL_W-1:0]   r;
      logic [QUO_W-1:0]   q;
   } lane_type;

   typedef struct packed {
      logic [3:0]                code;
      logic                      mean_above;
      logic signed [VAL_W-1:0]   x0;
      logic signed [VAL_W-1:0]   x1;
      logic signed [VAL_W-1:0]   y0;
      logic signed [VAL_W-1:0]   y1;
      lane_type [LANES-1:0]      ln;
   } dp_type;

   typedef struct packed {
      logic [3:0]                  code;
      logic                        mean_above;
      logic signed [VAL_W-1:0]     x0;
      logic signed [VAL_W-1:0]     x1;
      logic signed [VAL_W-1:0]     y0;
      logic signed [VAL_W-1:0]     y1;
      logic [LANES-1:0][VAL_W-1:0] p;
   } pts_type;

   // last member sits in the lowest bits: start x first on the bus
   typedef struct packed {
      logic [VAL_W-1:0] ye;
      logic [VAL_W-1:0] xe;
      logic [VAL_W-1:0] ys;
      logic [VAL_W-1:0] xs;
   } seg_type;

   // origin + product, clipped to the 32-bit range
   function automatic logic signed [VAL_W-1:0] coord_sat(
      input logic signed [VAL_W-1:0]  org,
      input logic signed [PROD_W-1:0] prod);
      logic signed [PROD_W:0] s;
      s = $signed({{(PROD_W-VAL_W+1){org[VAL_W-1]}}, org}) + $signed({prod[PROD_W-1], prod});
      if (s > $signed({{(PROD_W-VAL_W+1){1'b0}}, 1'b0, {(VAL_W-1){1'b1}}}))
         coord_sat = {1'b0, {(VAL_W-1){1'b1}}};
      else if (s < $signed({{(PROD_W-VAL_W+1){1'b1}}, 1'b1, {(VAL_W-1){1'b0}}}))
         coord_sat = {1'b1, {(VAL_W-1){1'b0}}};
      else
         coord_sat = s[VAL_W-1:0];
   endfunction

   // numerator and denominator magnitudes for one edge, remainder starts at n
   function automatic lane_type lane_setup(
      input logic signed [VAL_W-1:0] tgt,
      input logic signed [VAL_W-1:0] ca,
      input logic signed [VAL_W-1:0] cb);
      logic signed [VAL_W:0] num;
      logic signed [VAL_W:0] den;
      logic [VAL_W:0]        n;
      logic [VAL_W:0]        d;
      num = $signed({tgt[VAL_W-1], tgt}) - $signed({ca[VAL_W-1], ca});
      den = $signed({cb[VAL_W-1], cb}) - $signed({ca[VAL_W-1], ca});
      n = num[VAL_W] ? (~num + 1'b1) : num;
      d = den[VAL_W] ? (~den + 1'b1) : den;
      lane_setup.den_zero = (den == '0);
      lane_setup.opp      = (num != '0) && (num[VAL_W] != den[VAL_W]);
      lane_setup.f_one    = (n >= d);
      lane_setup.d        = d[VAL_W-1:0];
      lane_setup.r        = n[VAL_W-1:0];
      lane_setup.q        = '0;
   endfunction

endpackage

`default_nettype wire

/* sv/mscc_div_stage.sv */
// one quotient bit of the edge-fraction divider, four lanes side by side
// depends on mscc_pkg
`default_nettype none

module mscc_div_stage
   import mscc_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   en,
   input  wire logic   in_v,
   input  dp_type      in_d,
   output logic        out_v,
   output dp_type      out_d
);

   logic   v_ff;
   dp_type d_ff;
   dp_type d_in;

   always_comb begin
      logic [VAL_W:0] t;
      logic           ge;
      d_in = in_d;
      for (int i = 0; i < LANES; i++) begin
         t  = {in_d.ln[i].r, 1'b0};
         ge = (t >= {1'b0, in_d.ln[i].d});
         d_in.ln[i].r = ge ? VAL_W'(t - {1'b0, in_d.ln[i].d}) : t[VAL_W-1:0];
         d_in.ln[i].q = {in_d.ln[i].q[QUO_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in;
      end
   end

   assign out_v = v_ff;
   assign out_d = d_ff;

endmodule

`default_nettype wire

/* sv/mscc_interp.sv */
// crossing points: fraction times span with rounding, two stages
// depends on mscc_pkg
`default_nettype none

module mscc_interp
   import mscc_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   en,
   input  wire logic   in_v,
   input  dp_type      in_d,
   output logic        out_v,
   output pts_type     out_p
);

   localparam int MUL_W = 2 * VAL_W + 1;

   logic                             m_v_ff;
   logic [3:0]                       m_code_ff;
   logic                             m_mean_ff;
   logic signed [VAL_W-1:0]          m_x0_ff, m_x1_ff, m_y0_ff, m_y1_ff;
   logic [LANES-1:0][MUL_W-1:0]      m_prod_ff;
   logic [LANES-1:0][MUL_W-1:0]      m_prod_in;
   logic [LANES-1:0]                 m_neg_ff, m_neg_in;
   logic [LANES-1:0]                 m_zero_ff, m_opp_ff;
   logic [LANES-1:0][VAL_W-1:0]      m_ta_ff, m_ta_in;
   logic [LANES-1:0][VAL_W-1:0]      m_mid_ff, m_mid_in;

   logic                             p_v_ff;
   pts_type                          p_ff, p_in;

   always_comb begin
      logic signed [VAL_W-1:0] ta;
      logic signed [VAL_W-1:0] tb;
      logic signed [VAL_W:0]   span;
      logic signed [VAL_W:0]   sum;
      logic [VAL_W:0]          s;
      logic [VAL_W-1:0]        f;
      for (int i = 0; i < LANES; i++) begin
         // bottom and top edges run along x, right and left along y
         if (i == int'(PT_B) || i == int'(PT_T)) begin
            ta = in_d.x0;
            tb = in_d.x1;
         end else begin
            ta = in_d.y0;
            tb = in_d.y1;
         end
         span = $signed({tb[VAL_W-1], tb}) - $signed({ta[VAL_W-1], ta});
         sum  = $signed({tb[VAL_W-1], tb}) + $signed({ta[VAL_W-1], ta});
         s    = span[VAL_W] ? (~span + 1'b1) : span;
         f    = in_d.ln[i].f_one ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, in_d.ln[i].q};
         m_prod_in[i] = MUL_W'(f) * MUL_W'(s);
         m_neg_in[i]  = span[VAL_W];
         m_ta_in[i]   = ta;
         m_mid_in[i]  = sum[VAL_W:1];
      end
   end

   always_comb begin
      logic [MUL_W-1:0]        rnd;
      logic [VAL_W+1:0]        off;
      logic [VAL_W+1:0]        ta_x;
      logic [VAL_W+1:0]        res;
      p_in.code       = m_code_ff;
      p_in.mean_above = m_mean_ff;
      p_in.x0         = m_x0_ff;
      p_in.x1         = m_x1_ff;
      p_in.y0         = m_y0_ff;
      p_in.y1         = m_y1_ff;
      for (int i = 0; i < LANES; i++) begin
         rnd  = m_prod_ff[i] + (MUL_W'(1) << (VAL_W - 2));
         off  = {1'b0, rnd[MUL_W-2:VAL_W-1]};
         ta_x = {{2{m_ta_ff[i][VAL_W-1]}}, m_ta_ff[i]};
         res  = m_neg_ff[i] ? ta_x - off : ta_x + off;
         if (m_zero_ff[i])
            p_in.p[i] = m_mid_ff[i];
         else if (m_opp_ff[i])
            p_in.p[i] = m_ta_ff[i];
         else
            p_in.p[i] = res[VAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
         p_v_ff <= 1'b0;
      end else if (en) begin
         m_v_ff <= in_v;
         p_v_ff <= m_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_code_ff <= in_d.code;
         m_mean_ff <= in_d.mean_above;
         m_x0_ff   <= in_d.x0;
         m_x1_ff   <= in_d.x1;
         m_y0_ff   <= in_d.y0;
         m_y1_ff   <= in_d.y1;
         m_prod_ff <= m_prod_in;
         m_neg_ff  <= m_neg_in;
         m_ta_ff   <= m_ta_in;
         m_mid_ff  <= m_mid_in;
         for (int i = 0; i < LANES; i++) begin
            m_zero_ff[i] <= in_d.ln[i].den_zero;
            m_opp_ff[i]  <= in_d.ln[i].opp;
         end
         p_ff <= p_in;
      end
   end

   assign out_v = p_v_ff;
   assign out_p = p_ff;

endmodule

`default_nettype wire

/* sv/mscc_out.sv */
// output register: picks the segments of a cell and hands them out one word at a time
// depends on mscc_pkg; its advance signal steps the whole pipeline
`default_nettype none

module mscc_out
   import mscc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_v,
   input  pts_type            in_p,
   output logic               advance,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [4*VAL_W-1:0] rsp_tdata,
   output logic               rsp_tlast
);

   logic    v_ff, v_in;
   logic    two_ff, two_in;
   logic    phase_ff, phase_in;
   seg_type s0_ff, s0_in;
   seg_type s1_ff, s1_in;

   // point coordinates: x of bottom/top crossings is interpolated, right/left sit on a column
   function automatic logic [VAL_W-1:0] pt_x(input pts_type pp, input pt_type k);
      case (k)
         PT_R:    pt_x = pp.x1;
         PT_L:    pt_x = pp.x0;
         default: pt_x = pp.p[k];
      endcase
   endfunction

   // y of right/left crossings is interpolated, bottom/top sit on a row
   function automatic logic [VAL_W-1:0] pt_y(input pts_type pp, input pt_type k);
      case (k)
         PT_B:    pt_y = pp.y0;
         PT_T:    pt_y = pp.y1;
         default: pt_y = pp.p[k];
      endcase
   endfunction

   always_comb begin
      sel_type sel;
      pt_type  a0, b0, a1, b1;
      sel = SEG_TABLE[in_p.code];
      a0  = sel.a0;
      b0  = sel.b0;
      a1  = sel.a1;
      b1  = sel.b1;
      // other saddle pairing: left-bottom, then top-right
      if (sel.cnt == 2'd2 && ((in_p.code == CODE_SADDLE_BL_TR) != in_p.mean_above)) begin
         b0 = PT_B;
         a1 = PT_T;
      end
      s0_in    = '0;
      s1_in    = '0;
      s0_in.xs = pt_x(in_p, a0);
      s0_in.ys = pt_y(in_p, a0);
      s0_in.xe = pt_x(in_p, b0);
      s0_in.ye = pt_y(in_p, b0);
      s1_in.xs = pt_x(in_p, a1);
      s1_in.ys = pt_y(in_p, a1);
      s1_in.xe = pt_x(in_p, b1);
      s1_in.ye = pt_y(in_p, b1);

      advance  = !v_ff || (rsp_tready && rsp_tlast);
      v_in     = v_ff;
      two_in   = two_ff;
      phase_in = phase_ff;
      if (advance) begin
         v_in     = in_v && (sel.cnt != 2'd0);
         two_in   = (sel.cnt == 2'd2);
         phase_in = 1'b0;
      end else if (rsp_tready) begin
         phase_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= 1'b0;
         two_ff   <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         v_ff     <= v_in;
         two_ff   <= two_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_ff <= s0_in;
         s1_ff <= s1_in;
      end
   end

   assign rsp_tvalid = v_ff;
   assign rsp_tlast  = !(two_ff && !phase_ff);
   assign rsp_tdata  = phase_ff ? s1_ff : s0_ff;

endmodule

`default_nettype wire

/* sv/marching_squares_cell_contour.sv */
// top level: csr bank, input, setup and coordinate stages, divider chain, interpolation, output
// depends on mscc_pkg, mscc_div_stage, mscc_interp, mscc_out
//
//  channel  direction  word
//  req_     in         cell: col, row, side, four corner values
//  rsp_     out        segment: start x/y, end x/y; tlast on the cell's final segment
//  csr_     in         register index and 32-bit data, always ready
//
// a cell is captured into the input stage at its accepting edge and then passes setup,
// coordinates, 31 divider bits, two interpolation stages and the output register before
// its first segment is on rsp_. a cell enters every cycle while the output takes one
// segment per cycle; a two-segment cell holds the output register, and so the pipeline,
// until both its segments are taken. one stall signal from the output register freezes
// every stage at once. reset clears the valid bits and loads the register defaults.
`default_nettype none

module marching_squares_cell_contour
   import mscc_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int SIDE_MAX   = SIDE_MAX_DEF
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // cell_col, cell_row, cell_side, val_bl, val_br, val_tl, val_tr
   input  wire logic [167:0]          req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // seg_x_start, seg_y_start, seg_x_end, seg_y_end
   output logic [4*VAL_W-1:0]         rsp_tdata,
   output logic                       rsp_tlast,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [VAL_W-1:0]      csr_data
);

   localparam logic [15:0] COL_MASK = (COORD_BITS >= 16) ? 16'hFFFF :
                                      16'((32'd1 << COORD_BITS) - 32'd1);
   localparam logic [7:0]  SIDE_LIM = 8'(SIDE_MAX);

   logic signed [VAL_W-1:0] target_ff, x_org_ff, x_pitch_ff, y_org_ff, y_pitch_ff;

   logic en;

   // input stage
   logic                    a_v_ff;
   logic [15:0]             a_col_ff, a_row_ff;
   logic [7:0]              a_side_ff;
   logic signed [VAL_W-1:0] a_bl_ff, a_br_ff, a_tl_ff, a_tr_ff;

   // setup stage
   logic                     b_v_ff;
   logic [3:0]               b_code_ff, b_code_in;
   logic                     b_mean_ff, b_mean_in;
   logic signed [PROD_W-1:0] b_px0_ff, b_px1_ff, b_py0_ff, b_py1_ff;
   logic signed [PROD_W-1:0] b_px0_in, b_px1_in, b_py0_in, b_py1_in;
   lane_type [LANES-1:0]     b_ln_ff, b_ln_in;

   // coordinate stage
   logic   c_v_ff;
   dp_type c_ff, c_in;

   logic   dv [QUO_W+1];
   dp_type dd [QUO_W+1];

   logic    i_v;
   pts_type i_p;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff  <= '0;
         x_org_ff   <= '0;
         x_pitch_ff <= PITCH_RST;
         y_org_ff   <= '0;
         y_pitch_ff <= PITCH_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TARGET:   target_ff  <= csr_data;
            CSR_X_ORIGIN: x_org_ff   <= csr_data;
            CSR_X_PITCH:  x_pitch_ff <= csr_data;
            CSR_Y_ORIGIN: y_org_ff   <= csr_data;
            CSR_Y_PITCH:  y_pitch_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= req_tvalid;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
      end
   end

   always_comb begin
      logic [7:0]             side_c;
      logic [IDX_W-1:0]       cx0, cx1, ry0, ry1;
      logic signed [VAL_W+1:0] sum4;
      side_c = (a_side_ff == 8'd0) ? 8'd1 :
               (a_side_ff > SIDE_LIM) ? SIDE_LIM : a_side_ff;
      cx0 = IDX_W'(a_col_ff & COL_MASK);
      ry0 = IDX_W'(a_row_ff & COL_MASK);
      cx1 = cx0 + IDX_W'(side_c);
      ry1 = ry0 + IDX_W'(side_c);
      b_px0_in = $signed({1'b0, cx0}) * x_pitch_ff;
      b_px1_in = $signed({1'b0, cx1}) * x_pitch_ff;
      b_py0_in = $signed({1'b0, ry0}) * y_pitch_ff;
      b_py1_in = $signed({1'b0, ry1}) * y_pitch_ff;

      b_code_in = {a_tl_ff > target_ff, a_tr_ff > target_ff,
                   a_br_ff > target_ff, a_bl_ff > target_ff};
      sum4 = (VAL_W+2)'(a_bl_ff) + (VAL_W+2)'(a_br_ff) + (VAL_W+2)'(a_tl_ff) +
             (VAL_W+2)'(a_tr_ff);
      b_mean_in = sum4 > $signed({target_ff, 2'b00});

      b_ln_in[PT_B] = lane_setup(target_ff, a_bl_ff, a_br_ff);
      b_ln_in[PT_R] = lane_setup(target_ff, a_br_ff, a_tr_ff);
      b_ln_in[PT_T] = lane_setup(target_ff, a_tl_ff, a_tr_ff);
      b_ln_in[PT_L] = lane_setup(target_ff, a_bl_ff, a_tl_ff);
   end

   always_comb begin
      c_in.code       = b_code_ff;
      c_in.mean_above = b_mean_ff;
      c_in.x0         = coord_sat(x_org_ff, b_px0_ff);
      c_in.x1         = coord_sat(x_org_ff, b_px1_ff);
      c_in.y0         = coord_sat(y_org_ff, b_py0_ff);
      c_in.y1         = coord_sat(y_org_ff, b_py1_ff);
      c_in.ln         = b_ln_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_col_ff  <= req_tdata[15:0];
         a_row_ff  <= req_tdata[31:16];
         a_side_ff <= req_tdata[39:32];
         a_bl_ff   <= req_tdata[71:40];
         a_br_ff   <= req_tdata[103:72];
         a_tl_ff   <= req_tdata[135:104];
         a_tr_ff   <= req_tdata[167:136];
         b_code_ff <= b_code_in;
         b_mean_ff <= b_mean_in;
         b_px0_ff  <= b_px0_in;
         b_px1_ff  <= b_px1_in;
         b_py0_ff  <= b_py0_in;
         b_py1_ff  <= b_py1_in;
         b_ln_ff   <= b_ln_in;
         c_ff      <= c_in;
      end
   end

   assign dv[0] = c_v_ff;
   assign dd[0] = c_ff;

   for (genvar g = 0; g < QUO_W; g++) begin : g_div
      mscc_div_stage u_div (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .in_v  (dv[g]),
         .in_d  (dd[g]),
         .out_v (dv[g+1]),
         .out_d (dd[g+1])
      );
   end

   mscc_interp u_interp (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .in_v  (dv[QUO_W]),
      .in_d  (dd[QUO_W]),
      .out_v (i_v),
      .out_p (i_p)
   );

   mscc_out u_out (
      .clock      (clock),
      .reset      (reset),
      .in_v       (i_v),
      .in_p       (i_p),
      .advance    (en),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

/* sv/mscc_checker.sv */
// port-level checks on the contour block, attached by bind
// depends on mscc_pkg and marching_squares_cell_contour
`default_nettype none

module mscc_checker
   import mscc_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_tready,
   input wire logic               rsp_tvalid,
   input wire logic               rsp_tready,
   input wire logic [4*VAL_W-1:0] rsp_tdata,
   input wire logic               rsp_tlast
);

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   // a stalled output blocks the input side
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input ready while output stalled");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input not ready with empty output");

   // first segment of a pair is followed by the final one
   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && rsp_tlast)
      else $error("second segment of a cell missing");

endmodule

bind marching_squares_cell_contour mscc_checker u_mscc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
